// ----- hw/rtl/screv_pkg.sv -----
// ----------------------------------------------------------------------------
// screv_pkg
// Shared constants, register codes, delay-length tables and lane status type
// of the stereo comb/allpass reverberator.
// ----------------------------------------------------------------------------
package screv_pkg;

	// Parameter defaults
	localparam int COMB_COUNT_D    = 8;
	localparam int ALLPASS_COUNT_D = 4;
	localparam int STEREO_SPREAD_D = 23;
	localparam int SAMPLE_BITS_D   = 24;
	localparam int COEF_BITS_D     = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOM   = 3'd0,
		CFG_DAMP   = 3'd1,
		CFG_WET    = 3'd2,
		CFG_DRY    = 3'd3,
		CFG_WIDTH  = 3'd4,
		CFG_FREEZE = 3'd5,
		CFG_BYPASS = 3'd6
	} cfg_idx_t;

	localparam logic [15:0] ROOM_RST  = 16'd32768;
	localparam logic [15:0] DAMP_RST  = 16'd32768;
	localparam logic [15:0] WET_RST   = 16'd21845;
	localparam logic [15:0] DRY_RST   = 16'd0;
	localparam logic [15:0] WIDTH_RST = 16'd65535;

	// Ring position widths (longest line plus the largest spread)
	localparam int COMB_POS_W = 11;
	localparam int AP_POS_W   = 10;

	localparam int COMB_LEN_TAB [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int AP_LEN_TAB   [4] = '{556, 441, 341, 225};

	typedef struct packed {
		logic init_done;
		logic done;
	} lane_stat_t;

	function automatic int comb_total(int count, int spread);
		int t;
		t = 0;
		for (int i = 0; i < count; i++) begin
			t = t + COMB_LEN_TAB[i & 7] + spread;
		end
		return t;
	endfunction

	function automatic int ap_total(int count, int spread);
		int t;
		t = 0;
		for (int i = 0; i < count; i++) begin
			t = t + AP_LEN_TAB[i & 3] + spread;
		end
		return t;
	endfunction

	function automatic logic [COMB_POS_W-1:0] comb_len(logic [4:0] idx, int spread);
		return COMB_POS_W'(COMB_LEN_TAB[idx[2:0]] + spread);
	endfunction

	function automatic logic [AP_POS_W-1:0] ap_len(logic [4:0] idx, int spread);
		return AP_POS_W'(AP_LEN_TAB[idx[1:0]] + spread);
	endfunction

endpackage

// ----- hw/rtl/screv_ram.sv -----
// ----------------------------------------------------------------------------
// screv_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module screv_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- hw/rtl/screv_lane.sv -----
// ----------------------------------------------------------------------------
// screv_lane
// One channel: damped feedback combs in parallel (walked one at a time over a
// shared multiplier) followed by the series allpass chain.
// ----------------------------------------------------------------------------
module screv_lane #(
	parameter int COMB_COUNT    = 8,
	parameter int ALLPASS_COUNT = 4,
	parameter int SPREAD        = 0,
	parameter int SAMPLE_BITS   = 24,
	parameter int COEF_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS:0]   feed,
	input  logic        [COEF_BITS:0]     fb,
	input  logic        [COEF_BITS:0]     d1,
	input  logic        [COEF_BITS:0]     d2,
	output screv_pkg::lane_stat_t         stat,
	output logic signed [SAMPLE_BITS-1:0] wsum
);
	import screv_pkg::*;

	localparam int S     = SAMPLE_BITS;
	localparam int C     = COEF_BITS;
	localparam int CD    = comb_total(COMB_COUNT, SPREAD);
	localparam int AD    = ap_total(ALLPASS_COUNT, SPREAD);
	localparam int CAW   = $clog2(CD);
	localparam int AAW   = $clog2(AD);
	localparam int MAXD  = (CD > AD) ? CD : AD;
	localparam int CLW   = $clog2(MAXD + 1);
	localparam int CI_W  = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
	localparam int AI_W  = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
	localparam int PW    = S + C + 2;
	localparam int SW    = S + 6;
	localparam int ACC_W = S + $clog2(COMB_COUNT) + 1;
	localparam longint HALF = longint'(1) << (C - 1);
	localparam logic signed [SW-1:0] SMAX = SW'((longint'(1) << (S - 1)) - 1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	typedef enum logic [3:0] {
		L_CLEAR, L_IDLE, L_C_RD, L_C_M1, L_C_M2, L_C_M3, L_C_M4, L_C_WR, L_A_RD, L_A_WR
	} lane_state_t;

	function automatic logic signed [S-1:0] sat(input logic signed [SW-1:0] v);
		if (v > SMAX) return SMAX[S-1:0];
		if (v < SMIN) return SMIN[S-1:0];
		return v[S-1:0];
	endfunction

	function automatic logic signed [S+1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + PW'(HALF);
		return (S+2)'(t >>> C);
	endfunction

	lane_state_t              state_q;
	logic                     init_q, done_q;
	logic [CLW-1:0]           clr_q;
	logic [CI_W-1:0]          ci_q;
	logic [AI_W-1:0]          ai_q;
	logic [CAW-1:0]           cbase_q;
	logic [AAW-1:0]           abase_q;
	logic [COMB_POS_W-1:0]    cpos_q [COMB_COUNT];
	logic [AP_POS_W-1:0]      apos_q [ALLPASS_COUNT];
	logic signed [S-1:0]      lpv_q [COMB_COUNT];
	logic signed [S-1:0]      o_q, lp_q, x_q;
	logic signed [PW-1:0]     prod_q, prod2_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [COMB_POS_W-1:0]    clen, cpos;
	logic [COMB_POS_W:0]      cpos_nx;
	logic [AP_POS_W-1:0]      alen, apos;
	logic [AP_POS_W:0]        apos_nx;
	logic                     c_we, a_we;
	logic [CAW-1:0]           c_addr;
	logic [AAW-1:0]           a_addr;
	logic [S-1:0]             c_wdata, a_wdata, c_rdata, a_rdata;
	logic signed [S-1:0]      c_o, a_b, lp_new, comb_w, ap_w, x_new;
	logic signed [SW-1:0]     acc_all;

	assign clen    = comb_len(5'(ci_q), SPREAD);
	assign alen    = ap_len(5'(ai_q), SPREAD);
	assign cpos    = cpos_q[ci_q];
	assign apos    = apos_q[ai_q];
	assign cpos_nx = (COMB_POS_W+1)'(cpos) + (COMB_POS_W+1)'(1);
	assign apos_nx = (AP_POS_W+1)'(apos) + (AP_POS_W+1)'(1);
	assign c_o     = $signed(c_rdata);
	assign a_b     = $signed(a_rdata);

	// Datapath results of the current step
	assign lp_new  = sat(SW'(rnd(prod_q)) + SW'(rnd(prod2_q)));
	assign comb_w  = sat(SW'(feed) + SW'(rnd(prod_q)));
	assign acc_all = SW'(acc_q) + SW'(o_q);
	assign ap_w    = sat(SW'(x_q) + ((SW'(a_b) + SW'(1)) >>> 1));
	assign x_new   = sat(SW'(a_b) - SW'(x_q));

	always_comb begin
		c_we    = 1'b0;
		a_we    = 1'b0;
		c_addr  = cbase_q + CAW'(cpos);
		a_addr  = abase_q + AAW'(apos);
		c_wdata = comb_w;
		a_wdata = ap_w;
		unique case (state_q)
			L_CLEAR: begin
				c_we    = (clr_q < CLW'(CD));
				a_we    = (clr_q < CLW'(AD));
				c_addr  = CAW'(clr_q);
				a_addr  = AAW'(clr_q);
				c_wdata = '0;
				a_wdata = '0;
			end
			L_C_WR:  c_we = 1'b1;
			L_A_WR:  a_we = 1'b1;
			default: ;
		endcase
	end

	screv_ram #(.WIDTH(S), .DEPTH(CD)) u_comb_ram (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
	);

	screv_ram #(.WIDTH(S), .DEPTH(AD)) u_ap_ram (
		.clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_CLEAR;
			init_q  <= 1'b0;
			done_q  <= 1'b0;
			clr_q   <= '0;
			ci_q    <= '0;
			ai_q    <= '0;
			cbase_q <= '0;
			abase_q <= '0;
			for (int i = 0; i < COMB_COUNT; i++) begin
				cpos_q[i] <= '0;
				lpv_q[i]  <= '0;
			end
			for (int i = 0; i < ALLPASS_COUNT; i++) begin
				apos_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_CLEAR: begin
					if (clr_q == CLW'(MAXD)) begin
						init_q  <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						clr_q <= clr_q + CLW'(1);
					end
				end
				L_IDLE: begin
					if (start) begin
						ci_q    <= '0;
						cbase_q <= '0;
						acc_q   <= '0;
						state_q <= L_C_RD;
					end
				end
				L_C_RD: state_q <= L_C_M1;
				L_C_M1: begin
					o_q     <= c_o;
					prod_q  <= c_o * $signed({1'b0, d2});
					state_q <= L_C_M2;
				end
				L_C_M2: begin
					prod2_q <= lpv_q[ci_q] * $signed({1'b0, d1});
					state_q <= L_C_M3;
				end
				L_C_M3: begin
					lp_q         <= lp_new;
					lpv_q[ci_q]  <= lp_new;
					state_q      <= L_C_M4;
				end
				L_C_M4: begin
					prod_q  <= lp_q * $signed({1'b0, fb});
					state_q <= L_C_WR;
				end
				L_C_WR: begin
					// advance this comb's ring and fold its tap into the sum
					cpos_q[ci_q] <= (cpos_nx >= (COMB_POS_W+1)'(clen)) ? '0 : cpos_nx[COMB_POS_W-1:0];
					acc_q        <= ACC_W'(acc_all);
					cbase_q      <= cbase_q + CAW'(clen);
					if (ci_q == CI_W'(COMB_COUNT - 1)) begin
						x_q     <= sat(acc_all);
						ai_q    <= '0;
						abase_q <= '0;
						state_q <= L_A_RD;
					end else begin
						ci_q    <= ci_q + CI_W'(1);
						state_q <= L_C_RD;
					end
				end
				L_A_RD: state_q <= L_A_WR;
				L_A_WR: begin
					apos_q[ai_q] <= (apos_nx >= (AP_POS_W+1)'(alen)) ? '0 : apos_nx[AP_POS_W-1:0];
					x_q          <= x_new;
					abase_q      <= abase_q + AAW'(alen);
					if (ai_q == AI_W'(ALLPASS_COUNT - 1)) begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						ai_q    <= ai_q + AI_W'(1);
						state_q <= L_A_RD;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign stat.init_done = init_q;
	assign stat.done      = done_q;
	assign wsum           = x_q;

endmodule

// ----- hw/rtl/screv_mix.sv -----
// ----------------------------------------------------------------------------
// screv_mix
// Merge of the two lanes: wet/width cross-mix plus dry, one shared multiplier.
// ----------------------------------------------------------------------------
module screv_mix #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] wsum_l,
	input  logic signed [SAMPLE_BITS-1:0] wsum_r,
	input  logic signed [SAMPLE_BITS-1:0] dry_l,
	input  logic signed [SAMPLE_BITS-1:0] dry_r,
	input  logic        [COEF_BITS+1:0]   wet1,
	input  logic        [COEF_BITS+1:0]   wet2,
	input  logic        [COEF_BITS+1:0]   dry,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] left,
	output logic signed [SAMPLE_BITS-1:0] right
);
	import screv_pkg::*;

	localparam int S  = SAMPLE_BITS;
	localparam int C  = COEF_BITS;
	localparam int MW = S + C + 3;
	localparam int AW = MW + 2;
	localparam longint HALF = longint'(1) << (C - 1);
	localparam logic signed [AW-1:0] SMAX = AW'((longint'(1) << (S - 1)) - 1);
	localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
	localparam logic [2:0] LAST = 3'd5;

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_ACC, M_FIN} mix_state_t;

	function automatic logic signed [S-1:0] sat_rnd(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] t;
		t = (a + AW'(HALF)) >>> C;
		if (t > SMAX) return SMAX[S-1:0];
		if (t < SMIN) return SMIN[S-1:0];
		return t[S-1:0];
	endfunction

	mix_state_t          state_q;
	logic [2:0]          cnt_q;
	logic                done_q;
	logic signed [MW-1:0] prod_q;
	logic signed [AW-1:0] accl_q, accr_q;
	logic signed [S-1:0] left_q, right_q;
	logic signed [S-1:0] op_a;
	logic [C+1:0]        op_c;

	always_comb begin
		unique case (cnt_q)
			3'd0:    begin op_a = wsum_l; op_c = wet1; end
			3'd1:    begin op_a = wsum_r; op_c = wet2; end
			3'd2:    begin op_a = dry_l;  op_c = dry;  end
			3'd3:    begin op_a = wsum_r; op_c = wet1; end
			3'd4:    begin op_a = wsum_l; op_c = wet2; end
			3'd5:    begin op_a = dry_r;  op_c = dry;  end
			default: begin op_a = '0;     op_c = '0;   end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						accl_q  <= '0;
						accr_q  <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					prod_q  <= op_a * $signed({1'b0, op_c});
					state_q <= M_ACC;
				end
				M_ACC: begin
					if (cnt_q < 3'd3) accl_q <= accl_q + AW'(prod_q);
					else              accr_q <= accr_q + AW'(prod_q);
					cnt_q   <= cnt_q + 3'd1;
					state_q <= (cnt_q == LAST) ? M_FIN : M_MUL;
				end
				M_FIN: begin
					left_q  <= sat_rnd(accl_q);
					right_q <= sat_rnd(accr_q);
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign left  = left_q;
	assign right = right_q;

endmodule

// ----- hw/rtl/stereo_comb_allpass_reverb.sv -----
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// Stereo comb/allpass reverberator: two channel lanes and a wet/dry mixer.
// ----------------------------------------------------------------------------
// One stereo pair is taken per transfer and one result pair is returned.
// After reset the block sweeps its delay memories to zero, one entry a
// cycle, across the longest lane memory; configuration writes are taken
// during that time but no sample is. An item then passes the input gain
// (multiply, then round), the lane start, in each lane a read, the multiply
// and damping steps and a write per comb and then a read and a write per
// allpass (both lanes run side by side, one multiplier each), the hand-over
// to the mixer, the mixer (a multiply and an accumulate step for each of
// six products, the rounding step and its start and done hand-offs) and
// the load of the output register. The next item is taken only once the
// result sits in the output register, so no new pair is accepted while one
// is in flight. In bypass the input pair goes straight to the load of the
// output register, which waits for the register to be free, and no delay
// line moves.
// Configuration is to be written by the user only while no item is in
// flight; the block itself does not enforce this. The coefficient
// registers follow a write in the next cycle.
module stereo_comb_allpass_reverb #(
	parameter int COMB_COUNT    = screv_pkg::COMB_COUNT_D,
	parameter int ALLPASS_COUNT = screv_pkg::ALLPASS_COUNT_D,
	parameter int STEREO_SPREAD = screv_pkg::STEREO_SPREAD_D,
	parameter int SAMPLE_BITS   = screv_pkg::SAMPLE_BITS_D,
	parameter int COEF_BITS     = screv_pkg::COEF_BITS_D
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_BITS-1:0]         left_in,
	input  logic signed [SAMPLE_BITS-1:0]         right_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         left_out,
	output logic signed [SAMPLE_BITS-1:0]         right_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [screv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [screv_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import screv_pkg::*;

	localparam int S   = SAMPLE_BITS;
	localparam int C   = COEF_BITS;
	localparam int FPW = S + C + 3;
	localparam longint HALF = longint'(1) << (C - 1);
	localparam longint ONE  = longint'(1) << C;
	localparam longint GAIN = ((longint'(15) << C) + 500) / 1000;
	localparam longint K28  = ((longint'(28) << C) + 50) / 100;
	localparam longint K7   = ((longint'(7) << C) + 5) / 10;
	localparam longint K4   = ((longint'(4) << C) + 5) / 10;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FEED_MUL, ST_FEED_RND, ST_LANE, ST_MIX, ST_OUT
	} top_state_t;

	// ---------------- configuration registers ----------------
	logic [15:0] room_q, damp_q, wet_q, dry_q, width_q;
	logic        freeze_q, bypass_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q   <= ROOM_RST;
			damp_q   <= DAMP_RST;
			wet_q    <= WET_RST;
			dry_q    <= DRY_RST;
			width_q  <= WIDTH_RST;
			freeze_q <= 1'b0;
			bypass_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			// drop writes beyond the register list
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROOM:   room_q   <= cfg_data;
				CFG_DAMP:   damp_q   <= cfg_data;
				CFG_WET:    wet_q    <= cfg_data;
				CFG_DRY:    dry_q    <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_FREEZE: freeze_q <= cfg_data[0];
				CFG_BYPASS: bypass_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// ---------------- coefficients, refreshed every cycle ----------------
	logic [C:0]      gain_q, fb_q, d1_q, d2_q;
	logic [C+1:0]    wet1_q, wet2_q, dryc_q;
	logic [15+C:0]   room_prod, damp_prod;
	logic [17:0]     wet3;
	logic [16:0]     wa, wb;
	logic [34:0]     wp1, wp2;
	logic [16+C:0]   dry_sh;
	logic [C:0]      fb_c, d1_c;

	assign room_prod = (16+C)'(room_q) * (16+C)'(K28);
	assign damp_prod = (16+C)'(damp_q) * (16+C)'(K4);
	assign fb_c      = (C+1)'(room_prod >> 16) + (C+1)'(K7);
	assign d1_c      = (C+1)'(damp_prod >> 16);
	assign wet3      = {2'b00, wet_q} + {1'b0, wet_q, 1'b0};
	assign wa        = {1'b0, width_q} + 17'h10000;
	assign wb        = 17'h10000 - {1'b0, width_q};
	assign wp1       = 35'(wet3) * 35'(wa);
	assign wp2       = 35'(wet3) * 35'(wb);
	assign dry_sh    = (17+C)'({dry_q, 1'b0}) << C;

	always_ff @(posedge clk) begin
		// freeze: unity feedback, no damping, no input
		gain_q <= freeze_q ? '0 : (C+1)'(GAIN);
		fb_q   <= freeze_q ? (C+1)'(ONE) : fb_c;
		d1_q   <= freeze_q ? '0 : d1_c;
		d2_q   <= freeze_q ? (C+1)'(ONE) : (C+1)'(ONE) - d1_c;
		wet1_q <= (C+2)'(wp1 >> (33 - C));
		wet2_q <= (C+2)'(wp2 >> (33 - C));
		dryc_q <= (C+2)'(dry_sh >> 16);
	end

	// ---------------- sequencing ----------------
	top_state_t            state_q;
	logic                  byp_item_q, lane_start_q, mix_start_q, out_valid_q;
	logic signed [S-1:0]   in_l_q, in_r_q, out_l_q, out_r_q;
	logic signed [S:0]     in_sum, feed_q;
	logic signed [FPW-1:0] fprod_q;
	lane_stat_t            lane_stat [2];
	logic signed [S-1:0]   lane_wsum [2];
	logic                  mix_done, init_done, lanes_done, out_free, out_load;
	logic signed [S-1:0]   mix_l, mix_r;

	assign init_done  = lane_stat[0].init_done && lane_stat[1].init_done;
	assign lanes_done = lane_stat[0].done && lane_stat[1].done;
	assign in_ready   = (state_q == ST_IDLE) && init_done;
	assign in_sum     = (S+1)'(in_l_q) + (S+1)'(in_r_q);
	assign out_free   = !out_valid_q || out_ready;
	assign out_load   = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_l_q <= left_in;
			in_r_q <= right_in;
		end
		if (state_q == ST_FEED_MUL) begin
			fprod_q <= in_sum * $signed({1'b0, gain_q});
		end
		if (state_q == ST_FEED_RND) begin
			feed_q <= (S+1)'((fprod_q + FPW'(HALF)) >>> C);
		end
		if (out_load) begin
			out_l_q <= byp_item_q ? in_l_q : mix_l;
			out_r_q <= byp_item_q ? in_r_q : mix_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byp_item_q   <= 1'b0;
			lane_start_q <= 1'b0;
			mix_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			lane_start_q <= 1'b0;
			mix_start_q  <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						byp_item_q <= bypass_q;
						state_q    <= bypass_q ? ST_OUT : ST_FEED_MUL;
					end
				end
				ST_FEED_MUL: state_q <= ST_FEED_RND;
				ST_FEED_RND: begin
					lane_start_q <= 1'b1;
					state_q      <= ST_LANE;
				end
				ST_LANE: begin
					if (lanes_done) begin
						mix_start_q <= 1'b1;
						state_q     <= ST_MIX;
					end
				end
				ST_MIX: begin
					if (mix_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- channel lanes ----------------
	for (genvar g = 0; g < 2; g++) begin : g_lane
		screv_lane #(
			.COMB_COUNT   (COMB_COUNT),
			.ALLPASS_COUNT(ALLPASS_COUNT),
			.SPREAD       (g * STEREO_SPREAD),
			.SAMPLE_BITS  (SAMPLE_BITS),
			.COEF_BITS    (COEF_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.start (lane_start_q),
			.feed  (feed_q),
			.fb    (fb_q),
			.d1    (d1_q),
			.d2    (d2_q),
			.stat  (lane_stat[g]),
			.wsum  (lane_wsum[g])
		);
	end

	// ---------------- merge ----------------
	screv_mix #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_mix (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mix_start_q),
		.wsum_l(lane_wsum[0]),
		.wsum_r(lane_wsum[1]),
		.dry_l (in_l_q),
		.dry_r (in_r_q),
		.wet1  (wet1_q),
		.wet2  (wet2_q),
		.dry   (dryc_q),
		.done  (mix_done),
		.left  (mix_l),
		.right (mix_r)
	);

	assign out_valid = out_valid_q;
	assign left_out  = out_l_q;
	assign right_out = out_r_q;

	// ---------------- assertions ----------------
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_stat[0].done == lane_stat[1].done)
		else $error("lanes finished in different cycles");

	a_mix_done_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |-> state_q == ST_MIX)
		else $error("mixer finished outside the mix phase");

	a_accept_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> init_done)
		else $error("sample taken before the delay memories were cleared");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$rose(state_q == ST_IDLE) || !$past(out_load))
		else $error("pending result overwritten");

endmodule
